@@ design/fpa_pkg.sv @@
// ----------------------------------------------------------------------------
// fpa_pkg: shared types and constants for fixed_point_atan2
// Polynomial coefficients, reciprocal numerator and the flag bundles that
// ride alongside the divider chains.
// ----------------------------------------------------------------------------
`default_nettype none
package fpa_pkg;

  localparam logic [32:0] POLY_C0   = 33'd5653921792;
  localparam logic [14:0] POLY_C1   = 15'd22272;
  localparam logic [30:0] RECIP_NUM = 31'h7FFF_FFFF;
  localparam logic [7:0]  QUARTER   = 8'd128;
  localparam logic [9:0]  HALF_TURN = 10'd256;

  // divide by 1012: drop two bits, then multiply by ceil(2^39/253) and
  // keep bits 39 and up; exact for any dividend below 2^33
  localparam logic [31:0] RECIP_253 = 32'd2172947881;

  // quadrant and axis flags of one vector
  typedef struct packed {
    logic xz;    // x is zero
    logic yz;    // y is zero
    logic yneg;
    logic xneg;
  } flag_t;

  // side data through the reciprocal divider
  typedef struct packed {
    flag_t       flg;
    logic [31:0] mag;
  } side2_t;

  // side data through the constant divide
  typedef struct packed {
    flag_t       flg;
    logic        big;
    logic [15:0] t;
  } side3_t;

endpackage
`default_nettype wire

@@ design/fpa_div_cell.sv @@
// ----------------------------------------------------------------------------
// fpa_div_cell: one restoring division step
// Shifts in one numerator bit, trial-subtracts the divisor and registers
// the partial remainder, quotient and side data for the next cell.
// ----------------------------------------------------------------------------
`default_nettype none
module fpa_div_cell #(
  parameter int NW = 32,
  parameter int DW = 16,
  parameter int SW = 4
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          en,
  input  wire logic          in_valid,
  input  wire logic [DW-1:0] in_rem,
  input  wire logic [NW-1:0] in_num,
  input  wire logic [NW-1:0] in_quo,
  input  wire logic [DW-1:0] in_den,
  input  wire logic [SW-1:0] in_side,
  output logic               out_valid,
  output logic [DW-1:0]      out_rem,
  output logic [NW-1:0]      out_num,
  output logic [NW-1:0]      out_quo,
  output logic [DW-1:0]      out_den,
  output logic [SW-1:0]      out_side
);

  logic [DW:0]   trial;
  logic [DW:0]   diff;
  logic          ge;

  // trial subtract
  always_comb begin
    trial = {in_rem, in_num[NW-1]};
    diff  = trial - {1'b0, in_den};
    ge    = (trial >= {1'b0, in_den});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_rem  <= ge ? diff[DW-1:0] : trial[DW-1:0];
      out_num  <= {in_num[NW-2:0], 1'b0};
      out_quo  <= {in_quo[NW-2:0], ge};
      out_den  <= in_den;
      out_side <= in_side;
    end
  end

endmodule
`default_nettype wire

@@ design/fpa_div_chain.sv @@
// ----------------------------------------------------------------------------
// fpa_div_chain: pipelined unsigned divider
// A row of NW division cells, one quotient bit per cell, MSB first.
// ----------------------------------------------------------------------------
`default_nettype none
module fpa_div_chain #(
  parameter int NW = 32,
  parameter int DW = 16,
  parameter int SW = 4
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          en,
  input  wire logic          in_valid,
  input  wire logic [NW-1:0] num,
  input  wire logic [DW-1:0] den,
  input  wire logic [SW-1:0] in_side,
  output logic               out_valid,
  output logic [NW-1:0]      quo,
  output logic [SW-1:0]      out_side
);

  logic          v_w    [0:NW];
  logic [DW-1:0] rem_w  [0:NW];
  logic [NW-1:0] num_w  [0:NW];
  logic [NW-1:0] quo_w  [0:NW];
  logic [DW-1:0] den_w  [0:NW];
  logic [SW-1:0] side_w [0:NW];

  // chain inputs
  assign v_w[0]    = in_valid;
  assign rem_w[0]  = '0;
  assign num_w[0]  = num;
  assign quo_w[0]  = '0;
  assign den_w[0]  = den;
  assign side_w[0] = in_side;

  for (genvar i = 0; i < NW; i++) begin : g_cell
    fpa_div_cell #(.NW(NW), .DW(DW), .SW(SW)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .in_valid (v_w[i]),
      .in_rem   (rem_w[i]),
      .in_num   (num_w[i]),
      .in_quo   (quo_w[i]),
      .in_den   (den_w[i]),
      .in_side  (side_w[i]),
      .out_valid(v_w[i+1]),
      .out_rem  (rem_w[i+1]),
      .out_num  (num_w[i+1]),
      .out_quo  (quo_w[i+1]),
      .out_den  (den_w[i+1]),
      .out_side (side_w[i+1])
    );
  end

  assign out_valid = v_w[NW];
  assign quo       = quo_w[NW];
  assign out_side  = side_w[NW];

endmodule
`default_nettype wire

@@ design/fixed_point_atan2.sv @@
// ----------------------------------------------------------------------------
// fixed_point_atan2: angle of a vector in binary units (256 = pi)
// Throughput: one item per cycle while the skid slot is empty; the two division
// cell rows (32 and 31 cells) each retire one quotient bit per cell per cycle, and
// the divide by 1012 is a two-stage reciprocal multiply.
// Reset: synchronous, clears pipeline valid bits and the output/skid stage.
// ----------------------------------------------------------------------------
`default_nettype none
module fixed_point_atan2 (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [31:0] s_tdata,   // [15:0] vec_y, [31:16] vec_x
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [15:0]      m_tdata    // [9:0] angle, [15:10] zero
);
  import fpa_pkg::*;

  logic        en;
  logic        skid_valid;
  logic [9:0]  skid;

  // pipeline moves whenever the skid slot is free
  assign en       = ~skid_valid;
  assign s_tready = en;

  // ---------------- stage A: magnitudes and flags ----------------
  logic [15:0] vy, vx;
  logic [16:0] ey, ex;
  logic        a_valid;
  logic [15:0] a_ay, a_ax;
  flag_t       a_flg;

  assign vy = s_tdata[15:0];
  assign vx = s_tdata[31:16];
  assign ey = {vy[15], vy};
  assign ex = {vx[15], vx};

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (en) begin
      a_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    logic [16:0] my, mx;
    if (en) begin
      my = vy[15] ? (~ey + 17'd1) : ey;
      mx = vx[15] ? (~ex + 17'd1) : ex;
      a_ay       <= my[15:0];
      a_ax       <= mx[15:0];
      a_flg.xz   <= (vx == 16'd0);
      a_flg.yz   <= (vy == 16'd0);
      a_flg.yneg <= vy[15];
      a_flg.xneg <= vx[15];
    end
  end

  // ---------------- divider 1: |y|*65536 / |x| ----------------
  logic        d1_valid;
  logic [31:0] d1_quo;
  flag_t       d1_flg;

  fpa_div_chain #(.NW(32), .DW(16), .SW($bits(flag_t))) u_div_ratio (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (a_valid),
    .num      ({a_ay, 16'd0}),
    .den      (a_ax),
    .in_side  (a_flg),
    .out_valid(d1_valid),
    .quo      (d1_quo),
    .out_side (d1_flg)
  );

  // ---------------- divider 2: (2^31-1) / |z| ----------------
  logic        d2_valid;
  logic [30:0] d2_quo;
  side2_t      d2_in, d2_out;

  assign d2_in.flg = d1_flg;
  assign d2_in.mag = d1_quo;

  fpa_div_chain #(.NW(31), .DW(32), .SW($bits(side2_t))) u_div_recip (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (d1_valid),
    .num      (RECIP_NUM),
    .den      (d1_quo),
    .in_side  (d2_in),
    .out_valid(d2_valid),
    .quo      (d2_quo),
    .out_side (d2_out)
  );

  // ---------------- stage T: select t, form C0 - C1*t ----------------
  logic        t_valid;
  logic [32:0] t_poly;
  side3_t      t_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      t_valid <= 1'b0;
    end else if (en) begin
      t_valid <= d2_valid;
    end
  end

  always_ff @(posedge clk) begin
    logic        big;
    logic [15:0] t;
    logic [30:0] prod;
    if (en) begin
      big  = (d2_out.mag[31:16] != 16'd0);
      t    = big ? {d2_quo[14:0], 1'b0} : d2_out.mag[15:0];
      prod = POLY_C1 * t;
      t_poly       <= POLY_C0 - {2'b00, prod};
      t_side.flg   <= d2_out.flg;
      t_side.big   <= big;
      t_side.t     <= t;
    end
  end

  // ---------------- stage Q: divide by 1012, partial products ----------------
  logic        q_valid;
  logic [46:0] q_plo, q_phi;
  side3_t      q_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (en) begin
      q_valid <= t_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q_plo  <= t_poly[32:2] * RECIP_253[15:0];
      q_phi  <= t_poly[32:2] * RECIP_253[31:16];
      q_side <= t_side;
    end
  end

  // ---------------- stage D: sum partials, keep quotient ----------------
  logic        d3_valid;
  logic [22:0] d3_quo;
  side3_t      d3_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      d3_valid <= 1'b0;
    end else if (en) begin
      d3_valid <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    logic [62:0] sum;
    if (en) begin
      sum = {q_phi, 16'd0} + {16'd0, q_plo};
      d3_quo  <= sum[61:39];
      d3_side <= q_side;
    end
  end

  // ---------------- stage M: r * t ----------------
  logic        m_valid;
  logic [38:0] m_prod;
  flag_t       m_flg;
  logic        m_big;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (en) begin
      m_valid <= d3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_prod <= d3_quo * d3_side.t;
      m_flg  <= d3_side.flg;
      m_big  <= d3_side.big;
    end
  end

  // ---------------- stage F: octant fold, sign, half plane ----------------
  logic        f_valid;
  logic [9:0]  f_angle;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (en) begin
      f_valid <= m_valid;
    end
  end

  always_ff @(posedge clk) begin
    logic [7:0] at;
    logic [7:0] mg;
    logic [9:0] s;
    if (en) begin
      at = {1'b0, m_prod[38:32]};
      mg = m_big ? (QUARTER - at) : at;
      s  = (m_flg.yneg ^ m_flg.xneg) ? (10'd0 - {2'b00, mg}) : {2'b00, mg};
      if (m_flg.xneg) begin
        s = m_flg.yneg ? (s - HALF_TURN) : (s + HALF_TURN);
      end
      if (m_flg.xz) begin
        if (m_flg.yz) begin
          s = 10'd0;
        end else if (m_flg.yneg) begin
          s = 10'd0 - {2'b00, QUARTER};
        end else begin
          s = {2'b00, QUARTER};
        end
      end
      f_angle <= s;
    end
  end

  // ---------------- output register with skid slot ----------------
  logic p_fire;
  assign p_fire = en & f_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!m_tvalid || m_tready) begin
      if (skid_valid) begin
        m_tvalid   <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        m_tvalid <= p_fire;
      end
    end else if (p_fire) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!m_tvalid || m_tready) begin
      m_tdata <= {6'd0, (skid_valid ? skid : f_angle)};
    end else if (p_fire) begin
      skid <= f_angle;
    end
  end

endmodule
`default_nettype wire
